@@ rtl/core/rmet_pkg.sv @@
// Shared constants, types and microcode for the rational map escape-time unit.
package rmet_pkg;

   localparam int FRAC_BITS   = 24;
   localparam int COUNT_WIDTH = 16;
   localparam int DATA_W      = 32;
   localparam int PROD_W      = 2 * DATA_W - FRAC_BITS;
   localparam int ACC_W       = PROD_W + 2;
   localparam int NUM_W       = ACC_W - 1;
   localparam int DEN_W       = ACC_W - 1;
   localparam int DIV_STEPS   = NUM_W + FRAC_BITS;
   localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
   localparam int PC_W        = 6;

   localparam logic [COUNT_WIDTH-1:0] LIMIT_RESET = COUNT_WIDTH'(100);
   localparam logic [PC_W-1:0]        PC_CHECK    = PC_W'(11);

   localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};
   localparam logic signed [ACC_W-1:0]  ONE_FX   = ACC_W'(1) << FRAC_BITS;
   localparam logic [PROD_W:0]          ESC_LIMIT = (PROD_W+1)'(100) << FRAC_BITS;

   // multiplier operands
   localparam logic [2:0] OP_RE  = 3'd0;
   localparam logic [2:0] OP_IM  = 3'd1;
   localparam logic [2:0] OP_CRE = 3'd2;
   localparam logic [2:0] OP_CIM = 3'd3;
   localparam logic [2:0] OP_T1  = 3'd4;
   localparam logic [2:0] OP_T2  = 3'd5;
   localparam logic [2:0] OP_A   = 3'd6;
   localparam logic [2:0] OP_B   = 3'd7;

   // accumulator operations
   localparam logic [3:0] ACC_NOP  = 4'd0;
   localparam logic [3:0] ACC_LDP  = 4'd1;
   localparam logic [3:0] ACC_ADDP = 4'd2;
   localparam logic [3:0] ACC_SUBP = 4'd3;
   localparam logic [3:0] ACC_LDP2 = 4'd4;
   localparam logic [3:0] ACC_LDX  = 4'd5;
   localparam logic [3:0] ACC_ADDX = 4'd6;
   localparam logic [3:0] ACC_SUBX = 4'd7;
   localparam logic [3:0] ACC_NEGX = 4'd8;
   localparam logic [3:0] ACC_SAT  = 4'd9;

   // accumulator side operands
   localparam logic [3:0] X_ZERO = 4'd0;
   localparam logic [3:0] X_RE   = 4'd1;
   localparam logic [3:0] X_IM   = 4'd2;
   localparam logic [3:0] X_CRE  = 4'd3;
   localparam logic [3:0] X_CIM  = 4'd4;
   localparam logic [3:0] X_A    = 4'd5;
   localparam logic [3:0] X_B    = 4'd6;
   localparam logic [3:0] X_ONE  = 4'd7;
   localparam logic [3:0] X_SSRE = 4'd8;
   localparam logic [3:0] X_SSIM = 4'd9;

   // register destinations
   localparam logic [3:0] DST_NONE    = 4'd0;
   localparam logic [3:0] DST_T1      = 4'd1;
   localparam logic [3:0] DST_T2      = 4'd2;
   localparam logic [3:0] DST_A       = 4'd3;
   localparam logic [3:0] DST_B       = 4'd4;
   localparam logic [3:0] DST_SRE     = 4'd5;
   localparam logic [3:0] DST_SIM     = 4'd6;
   localparam logic [3:0] DST_DEN     = 4'd7;
   localparam logic [3:0] DST_DEN_DBL = 4'd8;
   localparam logic [3:0] DST_RE_Q    = 4'd9;
   localparam logic [3:0] DST_IM_Q    = 4'd10;

   // sequencing
   localparam logic [2:0] FL_NEXT  = 3'd0;
   localparam logic [2:0] FL_DIV   = 3'd1;
   localparam logic [2:0] FL_CHECK = 3'd2;
   localparam logic [2:0] FL_NWCHK = 3'd3;
   localparam logic [2:0] FL_LOOP  = 3'd4;

   typedef struct packed {
      logic [2:0] ma;
      logic [2:0] mb;
      logic [3:0] acc;
      logic [3:0] xs;
      logic [3:0] dst;
      logic [2:0] flow;
   } uins_type;

   typedef struct packed {
      logic       load;
      logic       div_start;
      logic [2:0] ma;
      logic [2:0] mb;
      logic [3:0] acc;
      logic [3:0] xs;
      logic [3:0] dst;
   } dp_cmd_type;

   typedef struct packed {
      logic c_zero;
      logic esc;
      logic acc_zero;
      logic div_done;
   } dp_stat_type;

   typedef struct packed {
      logic                   valid;
      logic [COUNT_WIDTH-1:0] count;
      logic                   ne;
   } res_type;

   function automatic uins_type mk(input logic [2:0] ma, input logic [2:0] mb,
                                   input logic [3:0] acc, input logic [3:0] xs,
                                   input logic [3:0] dst, input logic [2:0] flow);
      uins_type u;
      u.ma = ma; u.mb = mb; u.acc = acc; u.xs = xs; u.dst = dst; u.flow = flow;
      return u;
   endfunction

   function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [ACC_W-1:0] v);
      logic signed [DATA_W-1:0] r;
      if (&v[ACC_W-1:DATA_W-1] || ~|v[ACC_W-1:DATA_W-1]) begin
         r = v[DATA_W-1:0];
      end else if (v[ACC_W-1]) begin
         r = DATA_MIN;
      end else begin
         r = DATA_MAX;
      end
      return r;
   endfunction

   function automatic uins_type ucode(input logic [PC_W-1:0] pc);
      uins_type u;
      case (pc)
         6'd0:  u = mk(OP_CRE, OP_CRE, ACC_NOP,  X_ZERO, DST_NONE,    FL_NEXT);
         6'd1:  u = mk(OP_CIM, OP_CIM, ACC_LDP,  X_ZERO, DST_NONE,    FL_NEXT);
         6'd2:  u = mk(OP_RE,  OP_RE,  ACC_ADDP, X_ZERO, DST_NONE,    FL_NEXT);
         6'd3:  u = mk(OP_RE,  OP_RE,  ACC_ADDX, X_CRE,  DST_DEN_DBL, FL_NEXT);
         6'd4:  u = mk(OP_RE,  OP_RE,  ACC_NOP,  X_ZERO, DST_NONE,    FL_DIV);
         6'd5:  u = mk(OP_RE,  OP_RE,  ACC_NEGX, X_CIM,  DST_RE_Q,    FL_NEXT);
         6'd6:  u = mk(OP_RE,  OP_RE,  ACC_NOP,  X_ZERO, DST_NONE,    FL_DIV);
         6'd7:  u = mk(OP_RE,  OP_RE,  ACC_NOP,  X_ZERO, DST_IM_Q,    FL_NEXT);
         6'd8:  u = mk(OP_IM,  OP_IM,  ACC_LDP,  X_ZERO, DST_NONE,    FL_NEXT);
         6'd9:  u = mk(OP_RE,  OP_RE,  ACC_LDP,  X_ZERO, DST_SRE,     FL_NEXT);
         6'd10: u = mk(OP_RE,  OP_RE,  ACC_NOP,  X_ZERO, DST_SIM,     FL_NEXT);
         6'd11: u = mk(OP_RE,  OP_RE,  ACC_NOP,  X_ZERO, DST_NONE,    FL_CHECK);
         6'd12: u = mk(OP_RE,  OP_RE,  ACC_LDX,  X_SSRE, DST_NONE,    FL_NEXT);
         6'd13: u = mk(OP_RE,  OP_IM,  ACC_SUBX, X_SSIM, DST_NONE,    FL_NEXT);
         6'd14: u = mk(OP_RE,  OP_RE,  ACC_LDP2, X_ZERO, DST_T1,      FL_NEXT);
         6'd15: u = mk(OP_RE,  OP_RE,  ACC_NOP,  X_ZERO, DST_T2,      FL_NEXT);
         6'd16: u = mk(OP_T1,  OP_CRE, ACC_NOP,  X_ZERO, DST_NONE,    FL_NEXT);
         6'd17: u = mk(OP_T2,  OP_CIM, ACC_LDP,  X_ZERO, DST_NONE,    FL_NEXT);
         6'd18: u = mk(OP_RE,  OP_RE,  ACC_SUBP, X_ZERO, DST_NONE,    FL_NEXT);
         6'd19: u = mk(OP_CRE, OP_RE,  ACC_SAT,  X_ZERO, DST_NONE,    FL_NEXT);
         6'd20: u = mk(OP_CIM, OP_IM,  ACC_SUBP, X_ZERO, DST_NONE,    FL_NEXT);
         6'd21: u = mk(OP_CIM, OP_IM,  ACC_SUBX, X_RE,   DST_NONE,    FL_NEXT);
         6'd22: u = mk(OP_RE,  OP_RE,  ACC_ADDP, X_ZERO, DST_NONE,    FL_NEXT);
         6'd23: u = mk(OP_RE,  OP_RE,  ACC_ADDX, X_ONE,  DST_NONE,    FL_NEXT);
         6'd24: u = mk(OP_T2,  OP_CRE, ACC_NOP,  X_ZERO, DST_A,       FL_NEXT);
         6'd25: u = mk(OP_T1,  OP_CIM, ACC_LDP,  X_ZERO, DST_NONE,    FL_NEXT);
         6'd26: u = mk(OP_RE,  OP_RE,  ACC_ADDP, X_ZERO, DST_NONE,    FL_NEXT);
         6'd27: u = mk(OP_CRE, OP_IM,  ACC_SAT,  X_ZERO, DST_NONE,    FL_NEXT);
         6'd28: u = mk(OP_RE,  OP_RE,  ACC_SUBP, X_ZERO, DST_NONE,    FL_NEXT);
         6'd29: u = mk(OP_CIM, OP_RE,  ACC_SUBX, X_IM,   DST_NONE,    FL_NEXT);
         6'd30: u = mk(OP_RE,  OP_RE,  ACC_SUBP, X_ZERO, DST_NONE,    FL_NEXT);
         6'd31: u = mk(OP_RE,  OP_RE,  ACC_NOP,  X_ZERO, DST_B,       FL_NEXT);
         6'd32: u = mk(OP_A,   OP_A,   ACC_NOP,  X_ZERO, DST_NONE,    FL_NEXT);
         6'd33: u = mk(OP_B,   OP_B,   ACC_LDP,  X_ZERO, DST_NONE,    FL_NEXT);
         6'd34: u = mk(OP_RE,  OP_RE,  ACC_ADDP, X_ZERO, DST_NONE,    FL_NEXT);
         6'd35: u = mk(OP_RE,  OP_RE,  ACC_NOP,  X_ZERO, DST_DEN,     FL_NWCHK);
         6'd36: u = mk(OP_RE,  OP_RE,  ACC_LDX,  X_A,    DST_NONE,    FL_NEXT);
         6'd37: u = mk(OP_RE,  OP_RE,  ACC_NOP,  X_ZERO, DST_NONE,    FL_DIV);
         6'd38: u = mk(OP_RE,  OP_RE,  ACC_NEGX, X_B,    DST_RE_Q,    FL_NEXT);
         6'd39: u = mk(OP_RE,  OP_RE,  ACC_NOP,  X_ZERO, DST_NONE,    FL_DIV);
         6'd40: u = mk(OP_RE,  OP_RE,  ACC_NOP,  X_ZERO, DST_IM_Q,    FL_NEXT);
         6'd41: u = mk(OP_RE,  OP_RE,  ACC_NOP,  X_ZERO, DST_NONE,    FL_NEXT);
         6'd42: u = mk(OP_IM,  OP_IM,  ACC_LDP,  X_ZERO, DST_NONE,    FL_NEXT);
         6'd43: u = mk(OP_RE,  OP_RE,  ACC_LDP,  X_ZERO, DST_SRE,     FL_NEXT);
         6'd44: u = mk(OP_RE,  OP_RE,  ACC_NOP,  X_ZERO, DST_SIM,     FL_LOOP);
         default: u = mk(OP_RE, OP_RE, ACC_NOP,  X_ZERO, DST_NONE,    FL_LOOP);
      endcase
      return u;
   endfunction

endpackage

@@ rtl/core/rational_map_escape_time_unit.sv @@
// Top level of the rational map escape-time unit.
//
// Input words on req_* carry one parameter point c (Q8.24 real and imaginary
// parts). For each accepted word one result word appears on rsp_*: the
// escape-time count in rsp_tdata and the not-escaped flag in rsp_tuser.
// csr_* writes the 16-bit iteration limit (100 after reset); write it only
// while the unit is idle.
// One point is processed at a time. A zero point goes from the zero check
// straight to its result, without microcode. Otherwise the start value and
// each iteration run as microcode on the single shared 32x32 multiplier,
// each with two bit-serial divides of 65 steps.
// A finished result waits in the output register; while it is not taken the
// unit holds the next result in its controller and accepts no new word.
// Reset is synchronous; it empties the output register, idles the
// sequencer and restores the limit.
module rational_map_escape_time_unit import rmet_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [COUNT_WIDTH-1:0] csr_data,    // max_iterations
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [2*DATA_W-1:0]    req_tdata,   // c_real, c_imag
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [COUNT_WIDTH-1:0] rsp_tdata,   // iteration_count
   output logic [0:0]             rsp_tuser    // not_escaped
);

   dp_cmd_type             cmd;
   dp_stat_type            stat;
   res_type                res;
   logic                   slot_free;
   logic                   rsp_tvalid_ff, rsp_tvalid_in;
   logic [COUNT_WIDTH-1:0] rsp_count_ff;
   logic                   rsp_ne_ff;

   rmet_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .stat       (stat),
      .slot_free  (slot_free),
      .cmd        (cmd),
      .res        (res)
   );

   rmet_dp u_dp (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .c_real (req_tdata[DATA_W-1:0]),
      .c_imag (req_tdata[2*DATA_W-1:DATA_W]),
      .stat   (stat)
   );

   assign slot_free = !rsp_tvalid_ff || rsp_tready;

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      if (res.valid) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      if (res.valid) begin
         rsp_count_ff <= res.count;
         rsp_ne_ff    <= res.ne;
      end
   end

   assign rsp_tvalid   = rsp_tvalid_ff;
   assign rsp_tdata    = rsp_count_ff;
   assign rsp_tuser[0] = rsp_ne_ff;

endmodule

@@ rtl/core/rmet_div.sv @@
// Bit-serial restoring divider giving a saturated fixed-point quotient.
module rmet_div import rmet_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic signed [ACC_W-1:0]  num,
   input  logic [DEN_W-1:0]         den,
   output logic                     done,
   output logic signed [DATA_W-1:0] quot
);

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [DIV_CNT_W-1:0]     k_ff, k_in;
   logic [DIV_STEPS-1:0]     sh_ff, sh_in;
   logic [DEN_W-1:0]         r_ff, r_in;
   logic [DEN_W-1:0]         den_ff, den_in;
   logic [DATA_W:0]          q_ff, q_in;
   logic                     big_ff, big_in;
   logic                     neg_ff, neg_in;
   logic signed [DATA_W-1:0] quot_ff, quot_in;

   logic [ACC_W-1:0]  mag;
   logic [DEN_W:0]    rs;
   logic [DEN_W:0]    diff;
   logic              ge;
   logic [DATA_W:0]   qn;
   logic              bign;

   always_comb begin
      mag     = num[ACC_W-1] ? ACC_W'(-num) : ACC_W'(num);
      rs      = {r_ff, sh_ff[DIV_STEPS-1]};
      diff    = rs - {1'b0, den_ff};
      ge      = rs >= {1'b0, den_ff};
      qn      = big_ff ? q_ff : {q_ff[DATA_W-1:0], ge};
      bign    = big_ff | qn[DATA_W];
      busy_in = busy_ff;
      done_in = 1'b0;
      k_in    = k_ff;
      sh_in   = sh_ff;
      r_in    = r_ff;
      den_in  = den_ff;
      q_in    = q_ff;
      big_in  = big_ff;
      neg_in  = neg_ff;
      quot_in = quot_ff;
      if (start) begin
         neg_in = num[ACC_W-1];
         den_in = den;
         if (den == '0) begin
            done_in = 1'b1;
            if (mag == '0) begin
               quot_in = '0;
            end else if (num[ACC_W-1]) begin
               quot_in = DATA_MIN;
            end else begin
               quot_in = DATA_MAX;
            end
         end else begin
            busy_in = 1'b1;
            k_in    = DIV_CNT_W'(DIV_STEPS - 1);
            sh_in   = {mag[NUM_W-1:0], {FRAC_BITS{1'b0}}};
            r_in    = '0;
            q_in    = '0;
            big_in  = 1'b0;
         end
      end else if (busy_ff) begin
         sh_in  = {sh_ff[DIV_STEPS-2:0], 1'b0};
         r_in   = ge ? diff[DEN_W-1:0] : rs[DEN_W-1:0];
         q_in   = qn;
         big_in = bign;
         k_in   = k_ff - 1'b1;
         if (k_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            if (neg_ff) begin
               if (bign || (qn[DATA_W-1] && |qn[DATA_W-2:0])) begin
                  quot_in = DATA_MIN;
               end else begin
                  quot_in = DATA_W'(-qn);
               end
            end else if (bign || qn[DATA_W-1]) begin
               quot_in = DATA_MAX;
            end else begin
               quot_in = qn[DATA_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      k_ff    <= k_in;
      sh_ff   <= sh_in;
      r_ff    <= r_in;
      den_ff  <= den_in;
      q_ff    <= q_in;
      big_ff  <= big_in;
      neg_ff  <= neg_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

@@ rtl/core/rmet_dp.sv @@
// Datapath: operand registers, shared multiplier, accumulator and divider.
module rmet_dp import rmet_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  dp_cmd_type               cmd,
   input  logic signed [DATA_W-1:0] c_real,
   input  logic signed [DATA_W-1:0] c_imag,
   output dp_stat_type              stat
);

   logic signed [DATA_W-1:0] cre_ff, cim_ff, re_ff, im_ff, t1_ff, t2_ff, a_ff, b_ff;
   logic [PROD_W-1:0]        sre_ff, sim_ff;
   logic [DEN_W-1:0]         den_ff;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [PROD_W-1:0] p_ff, p_in;

   logic signed [DATA_W-1:0]   opa, opb;
   logic signed [2*DATA_W-1:0] prod;
   logic signed [ACC_W-1:0]    xv, pw;
   logic signed [DATA_W-1:0]   acc_sat, quot;
   logic                       div_done;
   logic [PROD_W:0]            nsum;

   function automatic logic signed [DATA_W-1:0] pick(input logic [2:0] s,
      input logic signed [DATA_W-1:0] re, input logic signed [DATA_W-1:0] im,
      input logic signed [DATA_W-1:0] cr, input logic signed [DATA_W-1:0] ci,
      input logic signed [DATA_W-1:0] t1, input logic signed [DATA_W-1:0] t2,
      input logic signed [DATA_W-1:0] a, input logic signed [DATA_W-1:0] b);
      logic signed [DATA_W-1:0] r;
      case (s)
         OP_RE:   r = re;
         OP_IM:   r = im;
         OP_CRE:  r = cr;
         OP_CIM:  r = ci;
         OP_T1:   r = t1;
         OP_T2:   r = t2;
         OP_A:    r = a;
         default: r = b;
      endcase
      return r;
   endfunction

   rmet_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (acc_ff),
      .den   (den_ff),
      .done  (div_done),
      .quot  (quot)
   );

   always_comb begin
      opa     = pick(cmd.ma, re_ff, im_ff, cre_ff, cim_ff, t1_ff, t2_ff, a_ff, b_ff);
      opb     = pick(cmd.mb, re_ff, im_ff, cre_ff, cim_ff, t1_ff, t2_ff, a_ff, b_ff);
      prod    = opa * opb;
      p_in    = prod[2*DATA_W-1:FRAC_BITS];
      pw      = ACC_W'(p_ff);
      acc_sat = sat_data(acc_ff);
      case (cmd.xs)
         X_RE:    xv = ACC_W'(re_ff);
         X_IM:    xv = ACC_W'(im_ff);
         X_CRE:   xv = ACC_W'(cre_ff);
         X_CIM:   xv = ACC_W'(cim_ff);
         X_A:     xv = ACC_W'(a_ff);
         X_B:     xv = ACC_W'(b_ff);
         X_ONE:   xv = ONE_FX;
         X_SSRE:  xv = ACC_W'(sat_data(ACC_W'(sre_ff)));
         X_SSIM:  xv = ACC_W'(sat_data(ACC_W'(sim_ff)));
         default: xv = '0;
      endcase
      case (cmd.acc)
         ACC_LDP:  acc_in = pw;
         ACC_ADDP: acc_in = acc_ff + pw;
         ACC_SUBP: acc_in = acc_ff - pw;
         ACC_LDP2: acc_in = pw <<< 1;
         ACC_LDX:  acc_in = xv;
         ACC_ADDX: acc_in = acc_ff + xv;
         ACC_SUBX: acc_in = acc_ff - xv;
         ACC_NEGX: acc_in = -xv;
         ACC_SAT:  acc_in = ACC_W'(acc_sat);
         default:  acc_in = acc_ff;
      endcase
      nsum = {1'b0, sre_ff} + {1'b0, sim_ff};
   end

   always_ff @(posedge clock) begin
      p_ff   <= p_in;
      acc_ff <= acc_in;
      if (cmd.load) begin
         cre_ff <= c_real;
         cim_ff <= c_imag;
      end
      case (cmd.dst)
         DST_T1:      t1_ff  <= acc_sat;
         DST_T2:      t2_ff  <= acc_sat;
         DST_A:       a_ff   <= acc_sat;
         DST_B:       b_ff   <= acc_sat;
         DST_SRE:     sre_ff <= acc_ff[PROD_W-1:0];
         DST_SIM:     sim_ff <= acc_ff[PROD_W-1:0];
         DST_DEN:     den_ff <= acc_ff[DEN_W-1:0];
         DST_DEN_DBL: den_ff <= {acc_ff[DEN_W-2:0], 1'b0};
         DST_RE_Q:    re_ff  <= quot;
         DST_IM_Q:    im_ff  <= quot;
         default: ;
      endcase
   end

   assign stat.c_zero   = (cre_ff == '0) && (cim_ff == '0);
   assign stat.esc      = nsum >= ESC_LIMIT;
   assign stat.acc_zero = acc_ff == '0;
   assign stat.div_done = div_done;

endmodule

@@ rtl/core/rmet_ctrl.sv @@
// Controller: microcode sequencer, iteration counter and limit register.
module rmet_ctrl import rmet_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [COUNT_WIDTH-1:0] csr_data,
   input  dp_stat_type            stat,
   input  logic                   slot_free,
   output dp_cmd_type             cmd,
   output res_type                res
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_ZCHK = 3'd1;
   localparam logic [2:0] ST_EXEC = 3'd2;
   localparam logic [2:0] ST_DIVW = 3'd3;
   localparam logic [2:0] ST_OUT  = 3'd4;

   logic [2:0]             state_ff, state_in;
   logic [PC_W-1:0]        pc_ff, pc_in;
   logic [COUNT_WIDTH-1:0] n_ff, n_in;
   logic [COUNT_WIDTH-1:0] lim_ff, lim_in;
   logic                   zero_ff, zero_in;
   uins_type               ins;
   logic                   below;

   always_comb begin
      ins        = ucode(pc_ff);
      below      = n_ff < lim_ff;
      state_in   = state_ff;
      pc_in      = pc_ff;
      n_in       = n_ff;
      zero_in    = zero_ff;
      lim_in     = csr_valid ? csr_data : lim_ff;
      req_tready = 1'b0;
      cmd.load      = 1'b0;
      cmd.div_start = 1'b0;
      cmd.ma        = ins.ma;
      cmd.mb        = ins.mb;
      cmd.acc       = ACC_NOP;
      cmd.xs        = X_ZERO;
      cmd.dst       = DST_NONE;
      res.valid = 1'b0;
      res.count = '0;
      res.ne    = 1'b0;
      if (!zero_ff) begin
         res.count = below ? n_ff : '0;
         res.ne    = ~below;
      end
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_ZCHK;
            end
         end
         ST_ZCHK: begin
            pc_in    = '0;
            n_in     = '0;
            zero_in  = stat.c_zero;
            state_in = stat.c_zero ? ST_OUT : ST_EXEC;
         end
         ST_EXEC: begin
            cmd.acc = ins.acc;
            cmd.xs  = ins.xs;
            cmd.dst = ins.dst;
            pc_in   = pc_ff + 1'b1;
            case (ins.flow)
               FL_DIV: begin
                  cmd.div_start = 1'b1;
                  state_in      = ST_DIVW;
               end
               FL_CHECK: begin
                  if (!(below && !stat.esc)) state_in = ST_OUT;
               end
               FL_NWCHK: begin
                  if (stat.acc_zero) begin
                     n_in     = n_ff + 1'b1;
                     state_in = ST_OUT;
                  end
               end
               FL_LOOP: begin
                  n_in  = n_ff + 1'b1;
                  pc_in = PC_CHECK;
               end
               default: ;
            endcase
         end
         ST_DIVW: begin
            if (stat.div_done) state_in = ST_EXEC;
         end
         ST_OUT: begin
            res.valid = slot_free;
            if (slot_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         lim_ff   <= LIMIT_RESET;
      end else begin
         state_ff <= state_in;
         lim_ff   <= lim_in;
      end
      pc_ff   <= pc_in;
      n_ff    <= n_in;
      zero_ff <= zero_in;
   end

   assign csr_ready = 1'b1;

   a_out_leaves: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && slot_free) |=> state_ff == ST_IDLE)
      else $error("result slot free but controller did not return to idle");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC) |-> (n_ff <= lim_ff))
      else $error("iteration count passed the limit");

   a_ne_zero: assert property (@(posedge clock) disable iff (reset)
      res.valid |-> !(res.ne && res.count != '0))
      else $error("not-escaped result carries a nonzero count");

   a_div_wait: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |=> state_ff == ST_DIVW)
      else $error("divide issued without waiting");

endmodule
